// File: design/sbgr_pkg.sv
// ----------------------------------------------------------------------------
// sbgr_pkg: shared types and constants of the speech block gate
// Sizes of the sample store, field widths, command and register codes, and
// the result flags that travel from the control unit to the output stage.
// ----------------------------------------------------------------------------
package sbgr_pkg;

    // Largest block the store can hold.
    localparam int MaxBlock = 1024;
    localparam int AddrW    = $clog2(MaxBlock);
    // Pointers and counters must hold MaxBlock itself.
    localparam int PtrW     = $clog2(MaxBlock + 1);

    localparam int SampleW  = 16;
    localparam int ThrW     = 15;
    localparam int LenW     = 11;
    localparam int CfgIdxW  = 2;

    // Energy sum of a full block and the threshold product.
    localparam int EnergyW  = SampleW - 1 + PtrW;
    localparam int ProdW    = ThrW + PtrW;
    localparam int CmpW     = (EnergyW > ProdW) ? EnergyW : ProdW;
    localparam int LenCmpW  = (LenW > PtrW) ? LenW : PtrW;

    localparam logic [ThrW-1:0] ThresholdReset   = ThrW'(350);
    localparam logic [LenW-1:0] BlockLengthReset = LenW'(800);

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] CfgEnergyThreshold = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgBlockLength     = CfgIdxW'(1);

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_PULL = 1'b1
    } cmd_t;

    // Flags of one result.
    typedef struct packed
    {
        logic sample_valid;
        logic last_of_block;
        logic push_refused;
        logic block_closed;
        logic block_kept;
    } res_t;

    // Request to the sample store.
    typedef struct packed
    {
        logic               wr_en;
        logic [AddrW-1:0]   wr_addr;
        logic [SampleW-1:0] wr_data;
        logic               rd_en;
        logic [AddrW-1:0]   rd_addr;
    } mem_req_t;

endpackage

// File: design/sbgr_store.sv
// ----------------------------------------------------------------------------
// sbgr_store: sample store of the speech block gate
// Single-port-write, single-port-read synchronous memory with registered
// read data. The read data holds until the next read request.
// ----------------------------------------------------------------------------
module sbgr_store
(
    input  logic                              clk,
    input  sbgr_pkg::mem_req_t                req,
    output logic [sbgr_pkg::SampleW-1:0]      rd_data
);

    logic [sbgr_pkg::SampleW-1:0] mem_reg [sbgr_pkg::MaxBlock];
    logic [sbgr_pkg::SampleW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/sbgr_ctrl.sv
// ----------------------------------------------------------------------------
// sbgr_ctrl: block control of the speech block gate
// Holds the block state, decides for each request whether the sample is
// stored or removes a run, closes blocks with the energy test and steps the
// readout of kept samples. Issues the store requests for each request.
// ----------------------------------------------------------------------------
module sbgr_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  sbgr_pkg::cmd_t                    command,
    input  logic [sbgr_pkg::SampleW-1:0]      sample_in,
    input  logic                              end_of_stream,
    input  logic [sbgr_pkg::ThrW-1:0]         energy_threshold,
    input  logic [sbgr_pkg::LenW-1:0]         block_length,
    output sbgr_pkg::mem_req_t                mem_req,
    output sbgr_pkg::res_t                    res
);

    localparam int PtrW    = sbgr_pkg::PtrW;
    localparam int SampleW = sbgr_pkg::SampleW;

    logic [PtrW-1:0]              wp_reg, wp_next;
    logic [PtrW:0]                mark_reg, mark_next;
    logic [SampleW-1:0]           hist1_reg, hist1_next;
    logic [SampleW-1:0]           hist2_reg, hist2_next;
    logic [SampleW-1:0]           hist3_reg, hist3_next;
    logic [sbgr_pkg::EnergyW-1:0] energy_reg, energy_next;
    logic [PtrW-1:0]              seen_reg, seen_next;
    logic [PtrW-1:0]              pend_reg, pend_next;
    logic [PtrW-1:0]              rp_reg, rp_next;

    logic [SampleW-1:0]           mag;
    logic                         is_run;
    logic [PtrW-1:0]              eff_len;
    logic [PtrW-1:0]              wp_plus;
    logic [PtrW-1:0]              wp_after;
    logic [sbgr_pkg::CmpW-1:0]    energy_sum;
    logic [sbgr_pkg::CmpW-1:0]    limit;
    logic [PtrW-1:0]              seen_plus;

    function automatic logic [PtrW-1:0] rp_plus(input logic [PtrW-1:0] rp);
        rp_plus = rp + PtrW'(1);
    endfunction

    // Magnitude of the sample; the most negative value maps to its true size.
    assign mag = sample_in[SampleW-1] ? (~sample_in + SampleW'(1)) : sample_in;

    // A run continues when the sample equals all three previous ones.
    assign is_run = (sample_in == hist1_reg) && (hist1_reg == hist2_reg)
                    && (hist2_reg == hist3_reg);

    // Block length in force, kept within one and the store size.
    always_comb
    begin
        priority if (block_length == '0)
        begin
            eff_len = PtrW'(1);
        end
        else if (sbgr_pkg::LenCmpW'(block_length) > sbgr_pkg::LenCmpW'(sbgr_pkg::MaxBlock))
        begin
            eff_len = PtrW'(sbgr_pkg::MaxBlock);
        end
        else
        begin
            eff_len = PtrW'(block_length);
        end
    end

    assign wp_plus    = wp_reg + PtrW'(1);
    assign seen_plus  = seen_reg + PtrW'(1);
    assign energy_sum = sbgr_pkg::CmpW'(energy_reg) + sbgr_pkg::CmpW'(mag);
    assign limit      = sbgr_pkg::CmpW'(energy_threshold) * sbgr_pkg::CmpW'(seen_plus);

    // Write pointer after this push, before a possible block close.
    always_comb
    begin
        if (is_run)
        begin
            wp_after = mark_reg[PtrW] ? wp_reg : mark_reg[PtrW-1:0];
        end
        else
        begin
            wp_after = wp_plus;
        end
    end

    // Next state, store requests and result flags.
    always_comb
    begin
        wp_next     = wp_reg;
        mark_next   = mark_reg;
        hist1_next  = hist1_reg;
        hist2_next  = hist2_reg;
        hist3_next  = hist3_reg;
        energy_next = energy_reg;
        seen_next   = seen_reg;
        pend_next   = pend_reg;
        rp_next     = rp_reg;
        mem_req     = '0;
        res         = '0;

        mem_req.wr_addr = wp_reg[sbgr_pkg::AddrW-1:0];
        mem_req.wr_data = sample_in;
        mem_req.rd_addr = rp_reg[sbgr_pkg::AddrW-1:0];

        if (go)
        begin
            unique case (command)
                sbgr_pkg::CMD_PULL:
                begin
                    if (pend_reg != '0)
                    begin
                        mem_req.rd_en     = 1'b1;
                        res.sample_valid  = 1'b1;
                        res.last_of_block = (pend_reg == PtrW'(1));
                        rp_next           = rp_plus(rp_reg);
                        pend_next         = pend_reg - PtrW'(1);
                    end
                end
                sbgr_pkg::CMD_PUSH:
                begin
                    if (pend_reg != '0)
                    begin
                        res.push_refused = 1'b1;
                    end
                    else
                    begin
                        energy_next   = sbgr_pkg::EnergyW'(energy_sum);
                        seen_next     = seen_plus;
                        wp_next       = wp_after;
                        mem_req.wr_en = !is_run && (wp_reg < PtrW'(sbgr_pkg::MaxBlock));
                        if (!is_run)
                        begin
                            mark_next = {1'b0, wp_plus} - (PtrW + 1)'(3);
                        end
                        hist3_next = hist2_reg;
                        hist2_next = hist1_reg;
                        hist1_next = sample_in;

                        // Block close: energy test, then a fresh block.
                        if ((seen_plus >= eff_len) || end_of_stream)
                        begin
                            res.block_closed = 1'b1;
                            if ((energy_sum > limit) && (wp_after != '0))
                            begin
                                res.block_kept = 1'b1;
                                pend_next      = wp_after;
                                rp_next        = '0;
                            end
                            wp_next     = '0;
                            mark_next   = '0;
                            hist1_next  = '0;
                            hist2_next  = '0;
                            hist3_next  = '0;
                            energy_next = '0;
                            seen_next   = '0;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            mark_reg   <= '0;
            hist1_reg  <= '0;
            hist2_reg  <= '0;
            hist3_reg  <= '0;
            energy_reg <= '0;
            seen_reg   <= '0;
            pend_reg   <= '0;
            rp_reg     <= '0;
        end
        else
        begin
            wp_reg     <= wp_next;
            mark_reg   <= mark_next;
            hist1_reg  <= hist1_next;
            hist2_reg  <= hist2_next;
            hist3_reg  <= hist3_next;
            energy_reg <= energy_next;
            seen_reg   <= seen_next;
            pend_reg   <= pend_next;
            rp_reg     <= rp_next;
        end
    end

endmodule

// File: design/speech_block_gate_run_remover_core.sv
// ----------------------------------------------------------------------------
// speech_block_gate_run_remover_core: energy gate with run removal
// Groups pushed audio samples into blocks, drops runs of four or more equal
// samples, keeps a block only when its energy passes the threshold, and
// returns kept samples on pull requests.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per transfer: s_tuser selects a push
// or a pull, s_tdata holds the sample and s_tlast closes a partial block.
// Every request gives exactly one result on the master stream: m_tdata holds
// the pulled sample (zero when none), m_tlast marks the last kept sample of a
// block and m_tuser carries the status flags.
// The edge that accepts a request updates the state, starts the store access
// and stages the flags; once the output register is free, the registered
// read data and the flags are loaded into it. The block accepts one request
// per cycle while the receiver keeps up; a new request enters while the
// previous result is moved to the output register. When the receiver stalls,
// the output register and one staged request are held and s_tready drops
// until the output register frees up. Reset clears the block state, the
// pending count and both registers to their defaults (threshold 350, block
// length 800). The sample store needs no clearing pass; only entries written
// in the current block are read. The configuration channel is always ready;
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module speech_block_gate_run_remover_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sbgr_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [sbgr_pkg::ThrW-1:0]           cfg_data,
    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sbgr_pkg::SampleW-1:0]        s_tdata,   // [15:0] sample_in
    input  logic                                s_tuser,   // [0] command
    input  logic                                s_tlast,   // end_of_stream
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sbgr_pkg::SampleW-1:0]        m_tdata,   // [15:0] sample_out
    output logic [3:0]                          m_tuser,   // [0] sample_valid,
                                                           // [1] push_refused,
                                                           // [2] block_closed,
                                                           // [3] block_kept
    output logic                                m_tlast    // last_of_block
);

    logic [sbgr_pkg::ThrW-1:0]    thr_reg, thr_next;
    logic [sbgr_pkg::LenW-1:0]    len_reg, len_next;

    logic                         go;
    logic                         s1_adv;
    logic                         s1_valid_reg, s1_valid_next;
    sbgr_pkg::res_t               s1_res_reg;
    sbgr_pkg::res_t               res;
    sbgr_pkg::mem_req_t           mem_req;
    logic [sbgr_pkg::SampleW-1:0] rd_data;

    logic                         out_valid_reg, out_valid_next;
    sbgr_pkg::res_t               out_res_reg;
    logic [sbgr_pkg::SampleW-1:0] out_sample_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        len_next = len_reg;
        if (cfg_valid)
        begin
            if (cfg_index == sbgr_pkg::CfgEnergyThreshold)
            begin
                thr_next = cfg_data;
            end
            else if (cfg_index == sbgr_pkg::CfgBlockLength)
            begin
                len_next = cfg_data[sbgr_pkg::LenW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= sbgr_pkg::ThresholdReset;
            len_reg <= sbgr_pkg::BlockLengthReset;
        end
        else
        begin
            thr_reg <= thr_next;
            len_reg <= len_next;
        end
    end

    // Request handshake: the staged request moves on when the output frees.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign go       = s_tvalid && s_tready;

    // Block control and sample store.
    sbgr_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .go               (go),
        .command          (sbgr_pkg::cmd_t'(s_tuser)),
        .sample_in        (s_tdata),
        .end_of_stream    (s_tlast),
        .energy_threshold (thr_reg),
        .block_length     (len_reg),
        .mem_req          (mem_req),
        .res              (res)
    );

    sbgr_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Stage that waits for the store read data.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (go)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_res_reg <= res;
        end
        if (s1_adv)
        begin
            out_res_reg    <= s1_res_reg;
            out_sample_reg <= s1_res_reg.sample_valid ? rd_data : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_res_reg.last_of_block;
    assign m_tuser  = {out_res_reg.block_kept, out_res_reg.block_closed,
                       out_res_reg.push_refused, out_res_reg.sample_valid};

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the speech block gate with run removal
// Drives push and pull requests on the request stream, mirrors the block's
// energy gate and run removal in a scoreboard class, and compares every
// result on the result stream with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;

    localparam int CfgIdxW  = sbgr_pkg::CfgIdxW;
    localparam int SampleW  = sbgr_pkg::SampleW;
    localparam int ThrW     = sbgr_pkg::ThrW;
    localparam int LenW     = sbgr_pkg::LenW;
    localparam int MaxBlock = sbgr_pkg::MaxBlock;
    localparam int AddrW    = sbgr_pkg::AddrW;
    localparam int PtrW     = sbgr_pkg::PtrW;
    localparam int EnergyW  = sbgr_pkg::EnergyW;

    localparam logic [ThrW-1:0]    ThresholdReset     = sbgr_pkg::ThresholdReset;
    localparam logic [LenW-1:0]    BlockLengthReset   = sbgr_pkg::BlockLengthReset;
    localparam logic [CfgIdxW-1:0] CfgEnergyThreshold = sbgr_pkg::CfgEnergyThreshold;
    localparam logic [CfgIdxW-1:0] CfgBlockLength     = sbgr_pkg::CfgBlockLength;

    // Unused register indexes; writes to them must change nothing.
    localparam logic [CfgIdxW-1:0] CfgUnusedLow  = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgUnusedHigh = CfgIdxW'(3);

    localparam int WatchLimit   = 2000;
    localparam int RandomTarget = 1100;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One result of the block, as it travels on the result stream.
    typedef struct packed
    {
        logic [SampleW-1:0] sample_out;
        logic               sample_valid;
        logic               last_of_block;
        logic               push_refused;
        logic               block_closed;
        logic               block_kept;
    } gate_result_t;

    // Mirror of the gate: block state, registers and the results it owes.
    class gate_tracker;
        logic [ThrW-1:0]         threshold;
        logic [LenW-1:0]         block_len;
        logic [SampleW-1:0]      store [MaxBlock];
        logic [PtrW-1:0]         wr_ptr;
        logic signed [PtrW:0]    rewind_mark;
        logic [SampleW-1:0]      hist1;
        logic [SampleW-1:0]      hist2;
        logic [SampleW-1:0]      hist3;
        logic [EnergyW-1:0]      energy;
        logic [PtrW-1:0]         seen;
        logic [PtrW-1:0]         kept_left;
        logic [PtrW-1:0]         rd_ptr;
        gate_result_t            outcomes [$];
        int                      errors;

        function new();
            threshold = ThresholdReset;
            block_len = BlockLengthReset;
            foreach (store[i])
            begin
                store[i] = '0;
            end
            clear_block();
            kept_left = '0;
            rd_ptr    = '0;
            errors    = 0;
        endfunction

        function void clear_block();
            wr_ptr      = '0;
            rewind_mark = '0;
            hist1       = '0;
            hist2       = '0;
            hist3       = '0;
            energy      = '0;
            seen        = '0;
        endfunction

        function void write_register(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] data);
            if (idx == CfgEnergyThreshold)
            begin
                threshold = data;
            end
            else if (idx == CfgBlockLength)
            begin
                block_len = data[LenW-1:0];
            end
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(sbgr_pkg::cmd_t cmd, logic [SampleW-1:0] smp, logic eos);
            gate_result_t    r;
            logic [SampleW:0] mag;
            logic [PtrW-1:0] limit;
            r = '0;
            if (cmd == sbgr_pkg::CMD_PULL)
            begin
                if (kept_left != 0)
                begin
                    r.sample_out    = (rd_ptr < MaxBlock) ? store[rd_ptr[AddrW-1:0]] : '0;
                    r.sample_valid  = 1'b1;
                    r.last_of_block = (kept_left == 1);
                    rd_ptr          = rd_ptr + PtrW'(1);
                    kept_left       = kept_left - PtrW'(1);
                end
            end
            else if (kept_left != 0)
            begin
                r.push_refused = 1'b1;
            end
            else
            begin
                mag    = smp[SampleW-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
                energy = energy + EnergyW'(mag);
                seen   = seen + PtrW'(1);
                // A fourth equal sample rewinds the write pointer over the run.
                if (smp == hist1 && hist1 == hist2 && hist2 == hist3)
                begin
                    if (rewind_mark >= 0)
                    begin
                        wr_ptr = rewind_mark[PtrW-1:0];
                    end
                end
                else
                begin
                    if (wr_ptr < MaxBlock)
                    begin
                        store[wr_ptr[AddrW-1:0]] = smp;
                    end
                    wr_ptr      = wr_ptr + PtrW'(1);
                    rewind_mark = $signed({1'b0, wr_ptr}) - $signed((PtrW + 1)'(3));
                end
                hist3 = hist2;
                hist2 = hist1;
                hist1 = smp;
                // A length of zero acts as one, anything above the store as its size.
                if (block_len == 0)
                begin
                    limit = PtrW'(1);
                end
                else if (block_len > MaxBlock)
                begin
                    limit = PtrW'(MaxBlock);
                end
                else
                begin
                    limit = PtrW'(block_len);
                end
                if (seen >= limit || eos)
                begin
                    r.block_closed = 1'b1;
                    if (64'(energy) > 64'(threshold) * 64'(seen) && wr_ptr != 0)
                    begin
                        r.block_kept = 1'b1;
                        kept_left    = wr_ptr;
                        rd_ptr       = '0;
                    end
                    clear_block();
                end
            end
            outcomes.push_back(r);
        endfunction

        function void check_field(string name, logic [SampleW-1:0] want,
                                  logic [SampleW-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_outcome(gate_result_t got);
            gate_result_t want;
            if (outcomes.size() == 0)
            begin
                $error("result arrived with no request waiting");
                errors++;
                return;
            end
            want = outcomes.pop_front();
            check_field("sample_out", want.sample_out, got.sample_out);
            check_field("sample_valid", 16'(want.sample_valid), 16'(got.sample_valid));
            check_field("last_of_block", 16'(want.last_of_block), 16'(got.last_of_block));
            check_field("push_refused", 16'(want.push_refused), 16'(got.push_refused));
            check_field("block_closed", 16'(want.block_closed), 16'(got.block_closed));
            check_field("block_kept", 16'(want.block_kept), 16'(got.block_kept));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [ThrW-1:0]     cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [SampleW-1:0]  s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [SampleW-1:0]  m_tdata;
    logic [3:0]          m_tuser;
    logic                m_tlast;

    gate_tracker         tracker;
    int                  send_gap_pct;
    int                  stall_pct;
    int                  requests_sent;
    int                  quiet_cycles;
    logic [SampleW-1:0]  run_val;
    int                  run_left;

    speech_block_gate_run_remover_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stalls at random at the current rate.
    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        gate_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sample_out    = m_tdata;
            got.sample_valid  = m_tuser[0];
            got.push_refused  = m_tuser[1];
            got.block_closed  = m_tuser[2];
            got.block_kept    = m_tuser[3];
            got.last_of_block = m_tlast;
            tracker.check_outcome(got);
        end
    end

    // Watchdog: ends the run after too many cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WatchLimit)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Next sample: random values with runs of equal samples mixed in.
    function logic [SampleW-1:0] next_sample(int run_min, int run_max, int run_pct);
        logic [SampleW-1:0] v;
        if (run_left > 0)
        begin
            run_left--;
            return run_val;
        end
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = 16'h8000;
            2:       v = 16'h7fff;
            3, 4:    v = 16'($urandom_range(510)) - 16'd255;
            default: v = 16'($urandom);
        endcase
        if ($urandom_range(99) < run_pct)
        begin
            run_val  = v;
            run_left = $urandom_range(run_max, run_min) - 1;
        end
        return v;
    endfunction

    function int unsigned urandom_word();
        return $urandom;
    endfunction

    // Sends one request and notes it in the tracker once accepted.
    task automatic send_req(sbgr_pkg::cmd_t cmd, logic [SampleW-1:0] smp, logic eos);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = smp;
        s_tlast  = eos;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        tracker.note_request(cmd, smp, eos);
        requests_sent++;
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (tracker.outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        tracker.write_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        logic [SampleW-1:0] run_pattern [8];
        int                 phase;
        int                 n;
        int                 random_base;
        idle_mode_t         mode;

        tracker       = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = sbgr_pkg::CMD_PUSH;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        send_gap_pct  = 0;
        stall_pct     = 0;
        requests_sent = 0;
        quiet_cycles  = 0;
        run_val       = '0;
        run_left      = 0;
        run_pattern   = '{16'h0000, 16'h0005, 16'h0005, 16'h0005,
                          16'h0005, 16'h0005, 16'h0007, 16'h7fff};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default registers: an empty pull with end_of_stream, a kept one-sample
        // block, a refused push while it waits, then its readout.
        send_req(sbgr_pkg::CMD_PULL, 16'h1234, 1'b1);
        send_req(sbgr_pkg::CMD_PUSH, 16'h8000, 1'b1);
        send_req(sbgr_pkg::CMD_PUSH, 16'h7fff, 1'b1);
        send_req(sbgr_pkg::CMD_PULL, 16'h0000, 1'b0);

        // Leading zeros and a run of five vanish from a block of eight.
        wait_idle();
        write_cfg(CfgEnergyThreshold, '0);
        write_cfg(CfgBlockLength, ThrW'(8));
        foreach (run_pattern[i])
        begin
            send_req(sbgr_pkg::CMD_PUSH, run_pattern[i], 1'b0);
        end
        send_req(sbgr_pkg::CMD_PULL, 16'h0000, 1'b0);
        send_req(sbgr_pkg::CMD_PULL, 16'hffff, 1'b1);

        // A loud block with nothing left after run removal is dropped.
        repeat (3) send_req(sbgr_pkg::CMD_PUSH, 16'h0005, 1'b0);
        send_req(sbgr_pkg::CMD_PUSH, 16'h0005, 1'b1);

        // Highest threshold: only full-scale negative samples pass it.
        wait_idle();
        write_cfg(CfgEnergyThreshold, 15'h7fff);
        write_cfg(CfgBlockLength, 15'h7fff);
        send_req(sbgr_pkg::CMD_PUSH, 16'h8000, 1'b1);
        send_req(sbgr_pkg::CMD_PULL, 16'h0000, 1'b0);
        send_req(sbgr_pkg::CMD_PUSH, 16'h7fff, 1'b1);

        // Writes to unused indexes, then a block length lowered mid-block.
        wait_idle();
        write_cfg(CfgUnusedLow, 15'h2aaa);
        write_cfg(CfgUnusedHigh, 15'h5555);
        write_cfg(CfgEnergyThreshold, '0);
        write_cfg(CfgBlockLength, ThrW'(8));
        send_req(sbgr_pkg::CMD_PUSH, 16'h0001, 1'b0);
        send_req(sbgr_pkg::CMD_PUSH, 16'h0002, 1'b0);
        wait_idle();
        write_cfg(CfgBlockLength, ThrW'(1));
        send_req(sbgr_pkg::CMD_PUSH, 16'h0003, 1'b0);
        repeat (3) send_req(sbgr_pkg::CMD_PULL, 16'(urandom_word()), 1'b0);

        // Random phases, each with its own registers and idle pattern.
        random_base = requests_sent;
        phase       = 0;
        while (requests_sent - random_base < RandomTarget)
        begin
            wait_idle();
            mode = idle_mode_t'(phase % 4);
            case (mode)
                IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin send_gap_pct = 82; stall_pct = 0;  end
                IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 82; end
                default:       begin send_gap_pct = 14; stall_pct = 14; end
            endcase

            if (phase == 4)
            begin
                // Read out pending samples and close the open block first, so
                // that the next block starts empty.
                while (tracker.kept_left != 0)
                begin
                    send_req(sbgr_pkg::CMD_PULL, 16'($urandom), 1'b0);
                end
                if (tracker.seen != 0)
                begin
                    send_req(sbgr_pkg::CMD_PUSH, 16'h0000, 1'b1);
                    while (tracker.kept_left != 0)
                    begin
                        send_req(sbgr_pkg::CMD_PULL, 16'($urandom), 1'b0);
                    end
                end
                wait_idle();
                // One full-size block: the length register above the store size
                // acts as the store size; long runs keep the readout short.
                write_cfg(CfgEnergyThreshold, ThrW'($urandom_range(20)));
                write_cfg(CfgBlockLength, ThrW'(2047));
                run_left = 0;
                repeat (MaxBlock)
                begin
                    send_req(sbgr_pkg::CMD_PUSH, next_sample(40, 120, 100), 1'b0);
                end
                while (tracker.kept_left != 0)
                begin
                    send_req(sbgr_pkg::CMD_PULL, 16'($urandom), 1'($urandom_range(1)));
                end
            end
            else
            begin
                case ($urandom_range(5))
                    0:       write_cfg(CfgEnergyThreshold, '0);
                    1:       write_cfg(CfgEnergyThreshold, 15'h7fff);
                    2:       write_cfg(CfgEnergyThreshold, ThrW'($urandom_range(300)));
                    3:       write_cfg(CfgEnergyThreshold, ThrW'($urandom_range(3000)));
                    4:       write_cfg(CfgEnergyThreshold, ThrW'($urandom_range(20000)));
                    default: write_cfg(CfgEnergyThreshold, ThrW'($urandom));
                endcase
                case ($urandom_range(9))
                    0:       write_cfg(CfgBlockLength, '0);
                    1:       write_cfg(CfgBlockLength, ThrW'($urandom_range(2047, 1025)));
                    2:       write_cfg(CfgBlockLength,
                                       {4'($urandom), 11'($urandom_range(16, 1))});
                    default: write_cfg(CfgBlockLength, ThrW'($urandom_range(16, 1)));
                endcase
                if ($urandom_range(3) == 0)
                begin
                    write_cfg($urandom_range(1) ? CfgUnusedLow : CfgUnusedHigh,
                              ThrW'($urandom));
                end

                n = $urandom_range(40, 20);
                for (int i = 0; i < n; i++)
                begin
                    // Once, the sender holds off until the block has drained.
                    if (phase == 1 && i == n / 2)
                    begin
                        wait_idle();
                    end
                    if (tracker.kept_left != 0)
                    begin
                        if ($urandom_range(99) < 12)
                        begin
                            send_req(sbgr_pkg::CMD_PUSH, next_sample(2, 7, 30),
                                     1'($urandom_range(1)));
                        end
                        else
                        begin
                            send_req(sbgr_pkg::CMD_PULL, 16'($urandom),
                                     1'($urandom_range(1)));
                        end
                    end
                    else if ($urandom_range(99) < 8)
                    begin
                        send_req(sbgr_pkg::CMD_PULL, 16'($urandom), 1'($urandom_range(1)));
                    end
                    else
                    begin
                        send_req(sbgr_pkg::CMD_PUSH, next_sample(2, 7, 30),
                                 $urandom_range(99) < 6);
                    end
                end
            end
            phase++;
        end

        // Drain and report.
        wait_idle();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.outcomes.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
